FILE: rtl/dip_pkg.sv
// Shared types, constants and control bundles for the double integer power unit.
`timescale 1ns / 1ps
package dip_pkg;

   typedef struct packed {
      logic        [63:0] base_bits;
      logic signed [31:0] exponent;
   } req_type;

   typedef struct packed {
      logic [63:0] power_bits;
      logic        invalid;
   } rsp_type;

   typedef enum logic {
      FPU_MUL,
      FPU_RCP
   } fpu_op_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;
      logic       set_one;
      logic       set_invalid;
      logic       set_inf;
      logic       fpu_start;
      fpu_op_type fpu_op;
      logic       b_base;
      logic       acc_write;
      logic       dec_bit;
      logic       emit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic neg;
      logic near;
      logic mag_zero;
      logic bit_zero;
      logic bit_set;
      logic acc_zero;
      logic fpu_done;
   } status_type;

   localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
   localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
   localparam logic [62:0] INF_MAG     = 63'h7FF0_0000_0000_0000;
   localparam logic [63:0] ONE_BITS    = 64'h3FF0_0000_0000_0000;
   // magnitude of the double nearest 1e-7
   localparam logic [62:0] NEAR_LIMIT  = 63'h3E7A_D7F2_9ABC_AF48;

endpackage

FILE: rtl/dip_fpu.sv
// Multi-cycle IEEE double multiplier and reciprocal unit, round to nearest even.
`timescale 1ns / 1ps
module dip_fpu (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  dip_pkg::fpu_op_type op,
   input  logic [63:0]        a,
   input  logic [63:0]        b,
   output logic               done,
   output logic [63:0]        result
);
   import dip_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_PRE, S_DIV, S_NORM, S_DENORM, S_ROUND
   } state_type;

   state_type          state_ff, state_in;
   logic               done_ff, done_in;
   logic [63:0]        res_ff, res_in;
   logic               sign_ff, sign_in;
   logic signed [13:0] e_ff, e_in;
   logic [52:0]        ma_ff, ma_in, mb_ff, mb_in;
   logic [105:0]       prod_ff, prod_in;
   logic [53:0]        pp_ff, pp_in;
   logic [5:0]         sh_ff, sh_in;
   logic [54:0]        rem_ff, rem_in;
   logic [55:0]        quo_ff, quo_in;
   logic [5:0]         cnt_ff, cnt_in;

   logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
   logic [10:0] a_ee, b_ee;
   logic [26:0] x, y;
   logic [54:0] rem_sub, rem_nxt;
   logic        ge;
   logic [55:0] quo_nxt;
   logic signed [13:0] neg_sh;
   logic [6:0]  dsh;
   logic [233:0] ext;
   logic [52:0] m;
   logic        up;
   logic [53:0] mr;
   logic [10:0] ebias;

   assign a_nan  = (&a[62:52]) && (|a[51:0]);
   assign a_inf  = (&a[62:52]) && !(|a[51:0]);
   assign a_zero = (a[62:0] == 63'd0);
   assign b_nan  = (&b[62:52]) && (|b[51:0]);
   assign b_inf  = (&b[62:52]) && !(|b[51:0]);
   assign b_zero = (b[62:0] == 63'd0);
   assign a_ee   = (a[62:52] == 11'd0) ? 11'd1 : a[62:52];
   assign b_ee   = (b[62:52] == 11'd0) ? 11'd1 : b[62:52];

   assign x       = cnt_ff[1] ? {1'b0, ma_ff[52:27]} : ma_ff[26:0];
   assign y       = cnt_ff[0] ? {1'b0, mb_ff[52:27]} : mb_ff[26:0];

   assign ge      = (rem_ff >= {2'b00, mb_ff});
   assign rem_sub = ge ? (rem_ff - {2'b00, mb_ff}) : rem_ff;
   assign rem_nxt = {rem_sub[53:0], 1'b0};
   assign quo_nxt = {quo_ff[54:0], ge};

   assign neg_sh  = 14'sd1 - e_ff;
   assign dsh     = (neg_sh > 14'sd127) ? 7'd127 : neg_sh[6:0];
   assign ext     = {prod_ff, 128'd0} >> dsh;

   assign m     = prod_ff[104:52];
   assign up    = prod_ff[51] && ((|prod_ff[50:0]) || m[0]);
   assign mr    = {1'b0, m} + {53'd0, up};
   assign ebias = e_ff[10:0] - 11'd1;

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      sign_in  = sign_ff;
      e_in     = e_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      prod_in  = prod_ff;
      pp_in    = pp_ff;
      sh_in    = sh_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cnt_in = 6'd0;
               if (op == FPU_MUL) begin
                  sign_in = a[63] ^ b[63];
                  if (a_nan) begin
                     res_in = a | QUIET_BIT; done_in = 1'b1;
                  end else if (b_nan) begin
                     res_in = b | QUIET_BIT; done_in = 1'b1;
                  end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
                     res_in = DEFAULT_NAN; done_in = 1'b1;
                  end else if (a_inf || b_inf) begin
                     res_in = {a[63] ^ b[63], INF_MAG}; done_in = 1'b1;
                  end else if (a_zero || b_zero) begin
                     res_in = {a[63] ^ b[63], 63'd0}; done_in = 1'b1;
                  end else begin
                     ma_in    = {a[62:52] != 11'd0, a[51:0]};
                     mb_in    = {b[62:52] != 11'd0, b[51:0]};
                     e_in     = $signed({3'b000, a_ee}) + $signed({3'b000, b_ee})
                                - 14'sd1023;
                     prod_in  = 106'd0;
                     state_in = S_MUL;
                  end
               end else begin
                  sign_in = a[63];
                  if (a_nan) begin
                     res_in = a | QUIET_BIT; done_in = 1'b1;
                  end else if (a_inf) begin
                     res_in = {a[63], 63'd0}; done_in = 1'b1;
                  end else if (a_zero) begin
                     res_in = {a[63], INF_MAG}; done_in = 1'b1;
                  end else begin
                     mb_in    = {a[62:52] != 11'd0, a[51:0]};
                     e_in     = $signed({3'b000, a_ee});
                     state_in = S_PRE;
                  end
               end
            end
         end
         S_MUL: begin
            // one 27x27 partial product per cycle, registered and accumulated in the next cycle
            pp_in  = x * y;
            sh_in  = (cnt_ff[1] ? 6'd27 : 6'd0) + (cnt_ff[0] ? 6'd27 : 6'd0);
            if (cnt_ff != 6'd0)
               prod_in = prod_ff + ({52'd0, pp_ff} << sh_ff);
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd4)
               state_in = S_NORM;
         end
         S_PRE: begin
            if (mb_ff[52]) begin
               rem_in   = {2'b00, 1'b1, 52'd0};
               quo_in   = 56'd0;
               e_in     = 14'sd2046 - e_ff;
               state_in = S_DIV;
            end else if (mb_ff[52:45] == 8'd0) begin
               mb_in = {mb_ff[44:0], 8'd0};
               e_in  = e_ff - 14'sd8;
            end else begin
               mb_in = {mb_ff[51:0], 1'b0};
               e_in  = e_ff - 14'sd1;
            end
         end
         S_DIV: begin
            rem_in = rem_nxt;
            quo_in = quo_nxt;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd55) begin
               prod_in  = {1'b0, quo_nxt, 48'd0, rem_nxt != 55'd0};
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (prod_ff[105]) begin
               prod_in  = {1'b0, prod_ff[105:2], prod_ff[1] | prod_ff[0]};
               e_in     = e_ff + 14'sd1;
               state_in = S_DENORM;
            end else if (prod_ff[104]) begin
               state_in = S_DENORM;
            end else if (prod_ff[104:97] == 8'd0) begin
               prod_in = {prod_ff[97:0], 8'd0};
               e_in    = e_ff - 14'sd8;
            end else begin
               prod_in = {prod_ff[104:0], 1'b0};
               e_in    = e_ff - 14'sd1;
            end
         end
         S_DENORM: begin
            // subnormal result: shift right, fold lost bits into sticky
            if (e_ff < 14'sd1) begin
               prod_in = {ext[233:129], ext[128] | (|ext[127:0])};
               e_in    = 14'sd1;
            end
            state_in = S_ROUND;
         end
         S_ROUND: begin
            if (e_ff > 14'sd2046)
               res_in = {sign_ff, INF_MAG};
            else
               res_in = {sign_ff, ebias, 52'd0} + {10'd0, mr};
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      res_ff  <= res_in;
      sign_ff <= sign_in;
      e_ff    <= e_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      prod_ff <= prod_in;
      pp_ff   <= pp_in;
      sh_ff   <= sh_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

FILE: rtl/dip_datapath.sv
// Datapath: operand registers, exponent scan, accumulator and the shared FPU.
`timescale 1ns / 1ps
module dip_datapath (
   input  logic                clock,
   input  logic                reset,
   input  dip_pkg::req_type    req_data,
   input  dip_pkg::cmd_type    cmd,
   output dip_pkg::status_type status,
   output dip_pkg::rsp_type    rsp_data
);
   import dip_pkg::*;

   logic [63:0] base_ff, base_in, acc_ff, acc_in;
   logic [31:0] mag_ff, mag_in;
   logic        neg_ff, neg_in, near_ff, near_in, inval_ff, inval_in;
   logic [4:0]  bit_ff, bit_in;
   rsp_type     rsp_ff, rsp_in;
   logic [31:0] e_raw, mag_new;
   logic [4:0]  top;
   logic        fpu_done;
   logic [63:0] fpu_res;

   assign e_raw   = req_data.exponent;
   assign mag_new = e_raw[31] ? (32'd0 - e_raw) : e_raw;

   always_comb begin
      top = 5'd0;
      for (int i = 0; i < 32; i++)
         if (mag_new[i]) top = 5'(i);
   end

   dip_fpu u_fpu (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.fpu_start),
      .op     (cmd.fpu_op),
      .a      (acc_ff),
      .b      (cmd.b_base ? base_ff : acc_ff),
      .done   (fpu_done),
      .result (fpu_res)
   );

   always_comb begin
      base_in  = base_ff;
      acc_in   = acc_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      near_in  = near_ff;
      inval_in = inval_ff;
      bit_in   = bit_ff;
      rsp_in   = rsp_ff;
      if (cmd.load) begin
         base_in  = req_data.base_bits;
         acc_in   = req_data.base_bits;
         mag_in   = mag_new;
         neg_in   = e_raw[31];
         near_in  = (req_data.base_bits[62:0] < NEAR_LIMIT);
         inval_in = 1'b0;
         bit_in   = top;
      end
      if (cmd.set_one)     acc_in = ONE_BITS;
      if (cmd.set_inf)     acc_in = {acc_ff[63], INF_MAG};
      if (cmd.set_invalid) begin
         acc_in   = 64'd0;
         inval_in = 1'b1;
      end
      if (cmd.acc_write)   acc_in = fpu_res;
      if (cmd.dec_bit)     bit_in = bit_ff - 5'd1;
      if (cmd.emit) begin
         rsp_in.power_bits = acc_ff;
         rsp_in.invalid    = inval_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff <= '0;
      end else begin
         rsp_ff <= rsp_in;
      end
      base_ff  <= base_in;
      acc_ff   <= acc_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      near_ff  <= near_in;
      inval_ff <= inval_in;
      bit_ff   <= bit_in;
   end

   assign status.neg      = neg_ff;
   assign status.near     = near_ff;
   assign status.mag_zero = (mag_ff == 32'd0);
   assign status.bit_zero = (bit_ff == 5'd0);
   assign status.bit_set  = mag_ff[bit_ff];
   assign status.acc_zero = (acc_ff[62:0] == 63'd0);
   assign status.fpu_done = fpu_done;
   assign rsp_data        = rsp_ff;

endmodule

FILE: rtl/dip_ctrl.sv
// Controller: sequences squarings, base multiplies, reciprocal and handshakes.
`timescale 1ns / 1ps
module dip_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  dip_pkg::status_type status,
   output dip_pkg::cmd_type    cmd
);
   import dip_pkg::*;

   typedef enum logic [3:0] {
      IDLE, CHECK, LOOP, SQR_WAIT, MULB, MULB_WAIT, POST, RCP_WAIT, FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.fpu_op = FPU_MUL;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CHECK;
            end
         end
         CHECK: begin
            if (status.neg && status.near) begin
               cmd.set_invalid = 1'b1;
               state_in        = FINISH;
            end else if (status.mag_zero) begin
               cmd.set_one = 1'b1;
               state_in    = FINISH;
            end else begin
               state_in = LOOP;
            end
         end
         LOOP: begin
            if (status.bit_zero) begin
               state_in = POST;
            end else begin
               cmd.fpu_start = 1'b1;
               cmd.dec_bit   = 1'b1;
               state_in      = SQR_WAIT;
            end
         end
         SQR_WAIT: begin
            if (status.fpu_done) begin
               cmd.acc_write = 1'b1;
               state_in      = status.bit_set ? MULB : LOOP;
            end
         end
         MULB: begin
            cmd.fpu_start = 1'b1;
            cmd.b_base    = 1'b1;
            state_in      = MULB_WAIT;
         end
         MULB_WAIT: begin
            if (status.fpu_done) begin
               cmd.acc_write = 1'b1;
               state_in      = LOOP;
            end
         end
         POST: begin
            if (!status.neg) begin
               state_in = FINISH;
            end else if (status.acc_zero) begin
               cmd.set_inf = 1'b1;
               state_in    = FINISH;
            end else begin
               cmd.fpu_start = 1'b1;
               cmd.fpu_op    = FPU_RCP;
               state_in      = RCP_WAIT;
            end
         end
         RCP_WAIT: begin
            if (status.fpu_done) begin
               cmd.acc_write = 1'b1;
               state_in      = FINISH;
            end
         end
         FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit = 1'b1;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
      rsp_valid_in = cmd.emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/double_integer_power_unit.sv
// Top level of the double integer power unit: controller plus datapath.
// Latency grows with the number of squarings and base multiplies, and a
// reciprocal follows when the exponent is negative; subnormal operands
// need extra normalize shifts.
// Throughput: one transaction at a time, set by the shared multi-cycle FPU
// (partial-product multiply, bit-serial reciprocal).
// Reset: synchronous, active high; clears the controller, FPU and output state.
`timescale 1ns / 1ps
module double_integer_power_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dip_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dip_pkg::rsp_type rsp_data
);
   import dip_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: accept in idle, walk exponent bits, hold result until taken
   dip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic: accumulator, base, exponent magnitude, FPU, output payload
   dip_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

FILE: dv/tb_double_integer_power_unit.sv
// Self-checking testbench for the double integer power unit.
`timescale 1ns / 1ps
module tb_double_integer_power_unit;
   import dip_pkg::*;

   // One queued request plus the idle cycles that come before it and an
   // optional hold until the unit has gone fully quiet.
   typedef struct {
      req_type req;
      int      gap;
      bit      drain;
   } power_job_type;

   localparam int STALL_LIMIT = 3000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   power_job_type job_queue[$];
   rsp_type       expected_powers[$];

   logic req_took = 1'b0;
   logic rsp_took = 1'b0;
   int   gap_left = 0;
   int   stall_left = 0;
   int   errors = 0;
   int   results_seen = 0;
   int   invalid_seen = 0;
   int   recip_seen = 0;
   int   quiet_cycles = 0;

   double_integer_power_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic bit is_nan(logic [63:0] v);
      return v[62:52] == 11'h7FF && v[51:0] != 52'd0;
   endfunction

   // Compute base ** exponent by left-to-right square and multiply in host
   // doubles, which round to nearest even just like the unit's FPU.
   function automatic rsp_type predict_power(req_type r);
      logic [31:0] eraw;
      logic        neg;
      logic [31:0] mag;
      real         b;
      real         acc;
      int          top;
      logic [63:0] pb;
      rsp_type     o;
      eraw = r.exponent;
      neg = eraw[31];
      mag = neg ? (32'd0 - eraw) : eraw;
      o.invalid = 1'b0;
      o.power_bits = ONE_BITS;
      // Near-zero base with negative exponent: flag it and return +0.
      if (neg && r.base_bits[62:0] < NEAR_LIMIT) begin
         o.power_bits = '0;
         o.invalid = 1'b1;
         return o;
      end
      if (mag == 32'd0) return o;
      // A NaN base propagates quieted through every multiply and the divide.
      if (is_nan(r.base_bits)) begin
         o.power_bits = r.base_bits | QUIET_BIT;
         return o;
      end
      b = $bitstoreal(r.base_bits);
      acc = b;
      top = 31;
      while (top > 0 && mag[top] == 1'b0) top--;
      for (int i = top - 1; i >= 0; i--) begin
         acc = acc * acc;
         if (mag[i]) acc = acc * b;
      end
      pb = $realtobits(acc);
      if (neg) begin
         // Reciprocal of a signed zero is the infinity of the same sign.
         if (pb[62:0] == 63'd0) pb = {pb[63], INF_MAG};
         else pb = $realtobits(1.0 / acc);
      end
      if (is_nan(pb)) pb = DEFAULT_NAN;
      o.power_bits = pb;
      return o;
   endfunction

   function automatic logic [63:0] near_one_base();
      return {1'($urandom), 1'b0, ($urandom_range(0, 1) ? 10'h3FF : 10'h3FE),
              20'($urandom), 32'($urandom)};
   endfunction

   task automatic add_job(logic [63:0] base, logic [31:0] expo, int gap, bit drain);
      power_job_type j;
      j.req.base_bits = base;
      j.req.exponent = expo;
      j.gap = gap;
      j.drain = drain;
      job_queue.push_back(j);
   endtask

   // Driver: launch a transaction at the falling edge and hold it until taken.
   always @(negedge clock) begin
      power_job_type j;
      logic          nv;
      nv = req_valid;
      if (reset) begin
         nv = 1'b0;
      end else if (!req_valid || req_took) begin
         nv = 1'b0;
         if (req_took) begin
            gap_left <= (job_queue.size() != 0) ? job_queue[0].gap : 0;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (job_queue.size() != 0) begin
            // Hold back a draining job until every expected result is in.
            if (!job_queue[0].drain || expected_powers.size() == 0) begin
               j = job_queue.pop_front();
               req_data <= j.req;
               nv = 1'b1;
            end
         end
      end
      req_valid <= nv;
   end

   // Result side back-pressure: draw a fresh stall after each transaction,
   // with a long stretch of no stalls every third block of 150 results.
   always @(negedge clock) begin
      logic ns;
      ns = 1'b0;
      if (!reset) begin
         if (rsp_took) begin
            if ((results_seen / 150) % 3 != 1) begin
               stall_left <= $urandom_range(0, 4);
            end
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            ns = 1'b1;
         end
      end
      rsp_stall <= ns;
   end

   // Monitor: predict on request acceptance, check on result acceptance.
   always @(posedge clock) begin
      rsp_type exp_r;
      req_took <= !reset && req_valid && !req_stall;
      rsp_took <= !reset && rsp_valid && !rsp_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (req_data.exponent < 0) recip_seen++;
            expected_powers.push_back(predict_power(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_powers.size() == 0) begin
               errors++;
               $display("%0t: unexpected result power_bits=%h invalid=%b",
                        $time, rsp_data.power_bits, rsp_data.invalid);
            end else begin
               exp_r = expected_powers.pop_front();
               if (exp_r.invalid) invalid_seen++;
               if (rsp_data.power_bits !== exp_r.power_bits) begin
                  errors++;
                  $display("%0t: power_bits mismatch expected=%h actual=%h",
                           $time, exp_r.power_bits, rsp_data.power_bits);
               end
               if (rsp_data.invalid !== exp_r.invalid) begin
                  errors++;
                  $display("%0t: invalid mismatch expected=%b actual=%b",
                           $time, exp_r.invalid, rsp_data.invalid);
               end
            end
         end
      end
   end

   // Watchdog: end the run if no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding",
                  $time, expected_powers.size());
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int pick;
      int gap;
      logic [31:0] expo;
      logic [63:0] base;

      // Directed: zero exponents on odd bases, near-zero limits, extremes.
      add_job(64'h7FF8_0000_0000_0001, 32'd0, 0, 0);          // NaN ** 0
      add_job(64'hFFF0_0000_0000_0000, 32'd0, 0, 0);          // -inf ** 0
      add_job(64'h0000_0000_0000_0000, 32'd0, 0, 0);          // 0 ** 0
      add_job(64'h4000_0000_0000_0000, 32'd1, 0, 0);          // 2 ** 1
      add_job(64'h4000_0000_0000_0000, 32'hFFFF_FFFF, 0, 0);  // 2 ** -1
      add_job(64'h3FF0_0000_0000_0001, 32'h7FFF_FFFF, 0, 0);  // largest exponent
      add_job(64'hBFEF_FFFF_FFFF_FFFF, 32'h8000_0000, 0, 0);  // most negative
      add_job(64'h0000_0000_0000_0000, -32'sd3, 0, 0);        // +0, negative
      add_job(64'h8000_0000_0000_0000, -32'sd2, 0, 0);        // -0, negative
      add_job(64'h0000_0000_0000_0001, -32'sd1, 0, 0);        // subnormal, negative
      add_job(64'h800F_FFFF_FFFF_FFFF, 32'd3, 0, 0);          // subnormal, positive
      add_job({1'b0, NEAR_LIMIT}, -32'sd1, 0, 0);             // exactly at limit
      add_job({1'b1, NEAR_LIMIT - 63'd1}, -32'sd1, 0, 0);     // just inside
      add_job({1'b1, NEAR_LIMIT}, -32'sd2, 0, 0);
      add_job(64'hC000_0000_0000_0000, 32'd7, 0, 0);          // negative base, odd
      add_job(64'h3EE4_F8B5_88E3_68F1, -32'sd100, 0, 0);      // 1e-5 ** -100 -> inf
      add_job(64'hBEE4_F8B5_88E3_68F1, -32'sd101, 0, 0);      // -> -inf
      add_job(64'h7FF4_0000_0000_0000, 32'd5, 0, 0);          // signaling NaN
      add_job(64'hFFF8_0000_0000_1234, -32'sd5, 0, 0);
      add_job(64'h7FF0_0000_0000_0000, -32'sd2, 0, 0);        // inf ** -2
      add_job(64'h4000_0000_0000_0000, 32'd1024, 0, 0);       // overflow
      add_job(64'h3FE0_0000_0000_0000, 32'd1074, 0, 0);       // smallest subnormal
      add_job(64'h3FE0_0000_0000_0000, 32'd1075, 0, 0);       // underflow to zero
      add_job(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0, 0);

      for (int n = 0; n < 1850; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            base = near_one_base();
            expo = $urandom_range(0, 2100);
            if ($urandom_range(0, 1)) expo = -expo;
         end else if (pick < 70) begin
            base = {$urandom, $urandom};
            expo = $urandom_range(0, 40);
            if ($urandom_range(0, 1)) expo = -expo;
         end else if (pick < 85) begin
            base = {$urandom, $urandom};
            expo = $urandom;
         end else if (pick < 93) begin
            // Tiny or subnormal bases around the near-zero cutoff.
            base = {1'($urandom), 11'($urandom_range(0, 12'h3E8)), 20'($urandom),
                    32'($urandom)};
            expo = $urandom_range(0, 8);
            if ($urandom_range(0, 1)) expo = -expo;
         end else begin
            base = near_one_base();
            expo = $urandom;
         end
         // Idle-free stretches every few hundred jobs.
         gap = ((n / 200) % 3 == 2) ? 0 : $urandom_range(0, 4);
         add_job(base, expo, gap, (n == 600 || n == 1300));
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      wait (job_queue.size() == 0 && !req_valid);
      wait (expected_powers.size() == 0);
      repeat (800) @(posedge clock);

      $display("Covered %0d results: %0d with negative exponent, %0d near-zero invalid.",
               results_seen, recip_seen, invalid_seen);
      if (errors == 0 && expected_powers.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: double_integer_power_unit.f
rtl/dip_pkg.sv
rtl/dip_fpu.sv
rtl/dip_datapath.sv
rtl/dip_ctrl.sv
rtl/double_integer_power_unit.sv
dv/tb_double_integer_power_unit.sv
